// ===== sv/ssu_pkg.sv =====
// Package for the sensor smoothing and slope unit.
// Holds field widths, CSR indexes, conversion constants and conversion functions.
// No dependencies.
package ssu_pkg;

   localparam int TEMP_IN_W   = 15;
   localparam int HUMID_IN_W  = 17;
   localparam int PRESS_IN_W  = 17;
   localparam int TEMP_W      = 17;
   localparam int HUMID_W     = 18;
   localparam int PRESS_W     = 18;
   localparam int SHIFT_W     = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 72;

   localparam int SLOPE_WINDOW_DEF = 16;
   localparam int HUMID_TAPS       = 4;
   localparam int RING_W           = $clog2(HUMID_TAPS);
   localparam int HSUM_W           = HUMID_W + RING_W;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

   localparam logic signed [TEMP_W-1:0]  TEMP_INVALID  = -17'sd256;
   localparam logic signed [HUMID_W-1:0] HUMID_INVALID = -18'sd1024;
   localparam logic signed [TEMP_W-1:0]  SAT_MAX       = 17'sd65535;
   localparam logic signed [TEMP_W-1:0]  SAT_MIN       = -17'sd65536;

   // floor(m / 125) = (m * ceil(2^32 / 125)) >> 32 for m below 2^25
   localparam logic [25:0] TEMP_RECIP  = 26'd34359739;
   // 576 * c + 62 + 125 * 76000 keeps the dividend positive
   localparam logic signed [25:0] TEMP_OFFSET = 26'sd9500062;
   // removes the 76000 bias and adds 32 F in Q8
   localparam logic signed [19:0] TEMP_UNBIAS = 20'sd67808;
   // round(2^42 * 6144000 / 5079583)
   localparam logic [42:0] PRESS_RECIP = 43'd5319648830273;
   localparam logic [59:0] PRESS_ROUND = 60'd2199023255552;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TEMP_SHIFT  = 2'd0,
      CSR_PRESS_SHIFT = 2'd1
   } csr_index_type;

   function automatic logic signed [TEMP_W-1:0] sat_slope(input logic signed [TEMP_W:0] v);
      logic signed [TEMP_W-1:0] r;
      if (v > 18'sd65535) begin
         r = SAT_MAX;
      end else if (v < -18'sd65536) begin
         r = SAT_MIN;
      end else begin
         r = v[TEMP_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TEMP_W-1:0] temp_to_fq8(
      input logic signed [TEMP_IN_W-1:0] c);
      logic signed [25:0] ms;
      logic [24:0]        m;
      logic [50:0]        prod;
      logic [18:0]        q;
      logic signed [19:0] r;
      logic signed [TEMP_W-1:0] f;
      ms   = 26'(c) * 26'sd576 + TEMP_OFFSET;
      m    = ms[24:0];
      prod = 51'(m) * 51'(TEMP_RECIP);
      q    = prod[50:32];
      r    = $signed({1'b0, q}) - TEMP_UNBIAS;
      if (r > 20'sd65535) begin
         f = SAT_MAX;
      end else if (r < -20'sd65536) begin
         f = SAT_MIN;
      end else begin
         f = r[TEMP_W-1:0];
      end
      return f;
   endfunction

   function automatic logic [PRESS_W-1:0] press_to_q12(input logic [PRESS_IN_W-1:0] pa);
      logic [59:0] prod;
      prod = 60'(pa) * 60'(PRESS_RECIP) + PRESS_ROUND;
      return prod[59:42];
   endfunction

endpackage

// ===== sv/sensor_smoothing_slope_unit.sv =====
// Sensor smoothing and slope unit: top level.
// Depends on ssu_pkg for widths, CSR indexes and unit conversions.
//
// Usage:
//   Requests enter on req_* (tvalid/tready). Each request is one measurement
//   set; exactly one result leaves on rsp_* per request, in order.
//   A request is converted to F in Q8 and inHg in Q12 as it is taken into the
//   input register; the filters, humidity ring and slope window update as it
//   moves into the result register, whose valid bit drives rsp_tvalid; one
//   request is taken every cycle while rsp_tready is high.
//   The filter and window state is the result register itself, so the
//   feedback through the filter update sets the one-cycle rate.
//   rsp_tlast marks the request that closed a slope window; rsp_tuser is the
//   sticky new-slope flag, cleared by the request's slope_ack bit.
//   When rsp_tready is low the result holds, the input register still takes
//   one request, and req_tready then drops until the result is taken.
//   Filter shifts must be written through csr_* only while no request is in
//   flight; the block does not enforce this. Synchronous reset empties both
//   registers, clears all filter state save the humidity ring, sets both
//   shifts to 4; the first request after reset seeds the filters and the ring.
module sensor_smoothing_slope_unit
   import ssu_pkg::*;
#(
   parameter int SLOPE_WINDOW = SLOPE_WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // temp_centi[14:0], humid_raw[31:15], press_pa[48:32], slope_ack[49], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // temp_ok[0], humid_ok[1]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // temp_f_q8[16:0], humid_avg[34:17], press_inhg_q12[52:35], slope_value[69:53], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // new_slope[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [SHIFT_W-1:0]    csr_wdata
);

   localparam int WIN_W = $clog2(SLOPE_WINDOW);
   localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(SLOPE_WINDOW - 1);
   localparam logic [RING_W-1:0] RING_LAST = RING_W'(HUMID_TAPS - 1);

   logic [SHIFT_W-1:0] temp_shift_ff, temp_shift_in;
   logic [SHIFT_W-1:0] press_shift_ff, press_shift_in;

   logic                       in_valid_ff, in_valid_in;
   logic signed [TEMP_W-1:0]   tx_ff, tx_in;
   logic signed [HUMID_W-1:0]  hx_ff, hx_in;
   logic [PRESS_W-1:0]         px_ff, px_in;
   logic                       ack_ff, ack_in;

   logic                       out_valid_ff, out_valid_in;
   logic                       primed_ff, primed_in;
   logic signed [TEMP_W-1:0]   temp_filt_ff, temp_filt_in;
   logic [PRESS_W-1:0]         press_filt_ff, press_filt_in;
   logic signed [HUMID_W-1:0]  humid_ring_ff [HUMID_TAPS];
   logic signed [HUMID_W-1:0]  humid_ring_in [HUMID_TAPS];
   logic [RING_W-1:0]          ring_pos_ff, ring_pos_in;
   logic [WIN_W-1:0]           win_count_ff, win_count_in;
   logic signed [TEMP_W-1:0]   win_first_ff, win_first_in;
   logic signed [TEMP_W-1:0]   slope_ff, slope_in;
   logic                       flag_ff, flag_in;
   logic signed [HUMID_W-1:0]  havg_ff, havg_in;
   logic                       done_ff, done_in;

   logic                       req_take;
   logic                       advance;
   logic signed [TEMP_W-1:0]   t_base;
   logic signed [TEMP_W:0]     t_diff;
   logic [PRESS_W-1:0]         p_base;
   logic signed [PRESS_W:0]    p_diff;
   logic signed [HSUM_W-1:0]   h_sum;
   logic signed [TEMP_W-1:0]   first_eff;
   logic                       win_end;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, slope_ff, press_filt_ff, havg_ff, temp_filt_ff};
   assign rsp_tuser  = flag_ff;
   assign rsp_tlast  = done_ff;

   always_comb begin
      temp_shift_in  = temp_shift_ff;
      press_shift_in = press_shift_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TEMP_SHIFT:  temp_shift_in  = csr_wdata;
            CSR_PRESS_SHIFT: press_shift_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // convert on the way into the input register
   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      tx_in  = tx_ff;
      hx_in  = hx_ff;
      px_in  = px_ff;
      ack_in = ack_ff;
      if (req_take) begin
         tx_in  = req_tuser[0] ? temp_to_fq8($signed(req_tdata[14:0])) : TEMP_INVALID;
         hx_in  = req_tuser[1] ? $signed({1'b0, req_tdata[31:15]}) : HUMID_INVALID;
         px_in  = press_to_q12(req_tdata[48:32]);
         ack_in = req_tdata[49];
      end
   end

   always_comb begin
      out_valid_in  = advance || (out_valid_ff && !rsp_tready);
      primed_in     = primed_ff;
      temp_filt_in  = temp_filt_ff;
      press_filt_in = press_filt_ff;
      ring_pos_in   = ring_pos_ff;
      win_count_in  = win_count_ff;
      win_first_in  = win_first_ff;
      slope_in      = slope_ff;
      flag_in       = flag_ff;
      havg_in       = havg_ff;
      done_in       = done_ff;

      t_base = primed_ff ? temp_filt_ff : tx_ff;
      t_diff = (TEMP_W+1)'(tx_ff) - (TEMP_W+1)'(t_base);
      p_base = primed_ff ? press_filt_ff : px_ff;
      p_diff = $signed({1'b0, px_ff}) - $signed({1'b0, p_base});

      h_sum = '0;
      for (int i = 0; i < HUMID_TAPS; i++) begin
         if (!primed_ff || ring_pos_ff == RING_W'(i)) begin
            humid_ring_in[i] = hx_ff;
         end else begin
            humid_ring_in[i] = humid_ring_ff[i];
         end
         h_sum = h_sum + HSUM_W'(humid_ring_in[i]);
      end

      win_end = (win_count_ff == WIN_LAST);

      if (advance) begin
         primed_in     = 1'b1;
         temp_filt_in  = TEMP_W'((TEMP_W+1)'(t_base) + (t_diff >>> temp_shift_ff));
         press_filt_in = PRESS_W'($signed({1'b0, p_base}) + (p_diff >>> press_shift_ff));
         ring_pos_in   = (ring_pos_ff == RING_LAST) ? '0 : ring_pos_ff + 1'b1;
         havg_in       = HUMID_W'(h_sum >>> RING_W);
         first_eff     = (win_count_ff == '0) ? temp_filt_in : win_first_ff;
         win_first_in  = first_eff;
         win_count_in  = win_end ? '0 : win_count_ff + 1'b1;
         flag_in       = (flag_ff && !ack_ff) || win_end;
         done_in       = win_end;
         if (win_end) begin
            slope_in = sat_slope((TEMP_W+1)'(temp_filt_in) - (TEMP_W+1)'(first_eff));
         end
      end else begin
         first_eff = win_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      hx_ff   <= hx_in;
      px_ff   <= px_in;
      ack_ff  <= ack_in;
      havg_ff <= havg_in;
      if (advance) begin
         for (int i = 0; i < HUMID_TAPS; i++) begin
            humid_ring_ff[i] <= humid_ring_in[i];
         end
      end
      if (reset) begin
         temp_shift_ff  <= SHIFT_RESET;
         press_shift_ff <= SHIFT_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         primed_ff      <= 1'b0;
         temp_filt_ff   <= '0;
         press_filt_ff  <= '0;
         ring_pos_ff    <= '0;
         win_count_ff   <= '0;
         win_first_ff   <= '0;
         slope_ff       <= '0;
         flag_ff        <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         temp_shift_ff  <= temp_shift_in;
         press_shift_ff <= press_shift_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         primed_ff      <= primed_in;
         temp_filt_ff   <= temp_filt_in;
         press_filt_ff  <= press_filt_in;
         ring_pos_ff    <= ring_pos_in;
         win_count_ff   <= win_count_in;
         win_first_ff   <= win_first_in;
         slope_ff       <= slope_in;
         flag_ff        <= flag_in;
         done_ff        <= done_in;
      end
   end

endmodule

// ===== sv/ssu_checker.sv =====
// Port-level checker for the sensor smoothing and slope unit, bound to the top level.
// Depends on ssu_pkg for port widths.
module ssu_checker
   import ssu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [SHIFT_W-1:0]    csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_window_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("window closed without new-slope flag");

   a_humid_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[34:17]) >= -18'sd1024)
      else $error("humidity average below invalid marker");

endmodule

bind sensor_smoothing_slope_unit ssu_checker u_ssu_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for sensor_smoothing_slope_unit: streams measurement requests with random
// sender gaps and receiver stalls, predicts each result in a scoreboard class and
// checks results in order. Depends on ssu_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_top
   import ssu_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic signed [TEMP_IN_W-1:0] temp_centi;
      logic                        temp_ok;
      logic [HUMID_IN_W-1:0]       humid_raw;
      logic                        humid_ok;
      logic [PRESS_IN_W-1:0]       press_pa;
      logic                        slope_ack;
   } reading_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp_f;
      logic signed [HUMID_W-1:0] humid_avg;
      logic [PRESS_W-1:0]        press;
      logic signed [TEMP_W-1:0]  slope;
      logic                      new_slope;
      logic                      window_done;
   } smoothed_type;

   typedef enum {MODE_WALK, MODE_EXTREME, MODE_NOISE} chunk_mode_type;

   class smoothing_scoreboard;
      logic [SHIFT_W-1:0] temp_shift;
      logic [SHIFT_W-1:0] press_shift;
      bit                 primed;
      longint             temp_filt;
      longint             press_filt;
      longint             humid_ring[HUMID_TAPS];
      int                 ring_pos;
      int                 window_count;
      longint             window_first;
      longint             slope_held;
      bit                 slope_flag;
      smoothed_type       expected_q[$];
      int                 mismatches;

      function new();
         temp_shift   = SHIFT_RESET;
         press_shift  = SHIFT_RESET;
         primed       = 1'b0;
         temp_filt    = 0;
         press_filt   = 0;
         foreach (humid_ring[i]) humid_ring[i] = 0;
         ring_pos     = 0;
         window_count = 0;
         window_first = 0;
         slope_held   = 0;
         slope_flag   = 1'b0;
         mismatches   = 0;
      endfunction

      static function longint clamp17(longint v);
         if (v > 65535) return 65535;
         if (v < -65536) return -65536;
         return v;
      endfunction

      static function longint fahrenheit_q8(longint c);
         longint n;
         longint q;
         n = 1152 * c + 125;
         if (n >= 0) begin
            q = n / 250;
         end else begin
            q = -((-n + 249) / 250);
         end
         return clamp17(q + 8192);
      endfunction

      static function longint inhg_q12(longint pa);
         return (2 * pa * 6144000 + 5079583) / (2 * 5079583);
      endfunction

      function void write_register(logic [CSR_ADDR_W-1:0] idx, logic [SHIFT_W-1:0] val);
         if (idx == CSR_TEMP_SHIFT) begin
            temp_shift = val;
         end else if (idx == CSR_PRESS_SHIFT) begin
            press_shift = val;
         end
      endfunction

      function void note_request(reading_type r);
         longint       tx;
         longint       hx;
         longint       px;
         longint       sum;
         longint       havg;
         smoothed_type e;
         e = '0;
         if (r.slope_ack) slope_flag = 1'b0;
         tx = r.temp_ok ? fahrenheit_q8(longint'(r.temp_centi)) : -256;
         hx = r.humid_ok ? longint'(r.humid_raw) : -1024;
         px = inhg_q12(longint'(r.press_pa));
         humid_ring[ring_pos] = hx;
         ring_pos = (ring_pos + 1) % HUMID_TAPS;
         if (!primed) begin
            temp_filt  = tx;
            press_filt = px;
            foreach (humid_ring[i]) humid_ring[i] = hx;
            primed = 1'b1;
         end
         temp_filt  += (tx - temp_filt) >>> temp_shift;
         press_filt += (px - press_filt) >>> press_shift;
         sum = 0;
         foreach (humid_ring[i]) sum += humid_ring[i];
         if (sum >= 0) begin
            havg = sum / HUMID_TAPS;
         end else begin
            havg = -((-sum + HUMID_TAPS - 1) / HUMID_TAPS);
         end
         if (window_count == 0) window_first = temp_filt;
         window_count++;
         if (window_count >= SLOPE_WINDOW_DEF) begin
            slope_held    = clamp17(temp_filt - window_first);
            window_count  = 0;
            slope_flag    = 1'b1;
            e.window_done = 1'b1;
         end
         e.temp_f    = temp_filt[TEMP_W-1:0];
         e.humid_avg = havg[HUMID_W-1:0];
         e.press     = press_filt[PRESS_W-1:0];
         e.slope     = slope_held[TEMP_W-1:0];
         e.new_slope = slope_flag;
         expected_q.push_back(e);
      endfunction

      task report(string field, longint got, longint want);
         $display("mismatch %s: got %0d, want %0d", field, got, want);
         mismatches++;
      endtask

      task check_result(smoothed_type got);
         smoothed_type want;
         if (expected_q.size() == 0) begin
            report("result without request", got.temp_f, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.temp_f !== want.temp_f)
               report("temp_f_q8", got.temp_f, want.temp_f);
            if (got.humid_avg !== want.humid_avg)
               report("humid_avg", got.humid_avg, want.humid_avg);
            if (got.press !== want.press)
               report("press_inhg_q12", got.press, want.press);
            if (got.slope !== want.slope)
               report("slope_value", got.slope, want.slope);
            if (got.new_slope !== want.new_slope)
               report("new_slope", got.new_slope, want.new_slope);
            if (got.window_done !== want.window_done)
               report("window_done", got.window_done, want.window_done);
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [SHIFT_W-1:0]    csr_wdata;

   smoothing_scoreboard sb;
   int tx_idle_pct  = 0;
   bit tx_quiet     = 1'b1;
   int rx_stall_pct = 0;
   bit rx_quiet     = 1'b1;

   sensor_smoothing_slope_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= rx_quiet || ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin : watch_rsp
      smoothed_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.temp_f      = rsp_tdata[TEMP_W-1:0];
         got.humid_avg   = rsp_tdata[TEMP_W +: HUMID_W];
         got.press       = rsp_tdata[TEMP_W+HUMID_W +: PRESS_W];
         got.slope       = rsp_tdata[TEMP_W+HUMID_W+PRESS_W +: TEMP_W];
         got.new_slope   = rsp_tuser;
         got.window_done = rsp_tlast;
         sb.check_result(got);
      end
   end

   task automatic write_register(input logic [CSR_ADDR_W-1:0] idx,
                                 input logic [SHIFT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_register(idx, val);
   endtask

   task automatic send_reading(input reading_type r);
      int gap;
      gap = 0;
      if (!tx_quiet) begin
         while ($urandom_range(99) < tx_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({r.slope_ack, r.press_pa, r.humid_raw, r.temp_centi});
      req_tuser  <= {r.humid_ok, r.temp_ok};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
   endtask

   // hold off new requests until every result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic reading_type directed_reading(input int k);
      reading_type r;
      r = '0;
      r.temp_ok    = 1'b1;
      r.humid_ok   = 1'b1;
      r.temp_centi = 16383;
      r.humid_raw  = 51200;
      r.press_pa   = 101325;
      case (k)
         0: begin
            r.temp_centi = -16384;
            r.humid_raw  = 0;
            r.press_pa   = 0;
         end
         1: begin
            r.temp_ok   = 1'b0;
            r.humid_raw = 17'h1FFFF;
            r.press_pa  = 17'h1FFFF;
         end
         2: begin
            r.temp_centi = 8500;
            r.humid_ok   = 1'b0;
            r.press_pa   = 110000;
         end
         3: begin
            r.temp_centi = -4000;
            r.humid_raw  = 102400;
            r.press_pa   = 30000;
         end
         4: begin
            r.temp_centi = 0;
            r.temp_ok    = 1'b0;
            r.humid_ok   = 1'b0;
            r.slope_ack  = 1'b1;
         end
         // ack lands on the request that closes the window
         15: r.slope_ack = 1'b1;
         16: begin
            r.temp_centi = -16384;
            r.press_pa   = 0;
         end
         17: begin
            r.temp_centi = 1234;
            r.slope_ack  = 1'b1;
         end
         18: r.humid_ok = 1'b0;
         19: r.temp_centi = -1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic reading_type random_reading(input chunk_mode_type mode, inout int walk);
      reading_type r;
      int          pick;
      r = '0;
      case (mode)
         MODE_WALK: begin
            walk = walk + int'($urandom_range(400)) - 200;
            if (walk > 8500) walk = 8500;
            if (walk < -4000) walk = -4000;
            r.temp_centi = TEMP_IN_W'(walk);
            r.temp_ok    = ($urandom_range(19) != 0);
            r.humid_raw  = HUMID_IN_W'($urandom_range(102400));
            r.humid_ok   = ($urandom_range(19) != 0);
            r.press_pa   = PRESS_IN_W'($urandom_range(110000, 30000));
         end
         MODE_EXTREME: begin
            pick = $urandom_range(3);
            if (pick == 0) begin
               r.temp_centi = 16383;
            end else if (pick == 1) begin
               r.temp_centi = -16384;
            end else begin
               r.temp_centi = TEMP_IN_W'($urandom);
            end
            r.temp_ok   = ($urandom_range(9) != 0);
            r.humid_raw = $urandom_range(1) ? 17'h1FFFF : 17'h0;
            r.humid_ok  = ($urandom_range(9) != 0);
            r.press_pa  = $urandom_range(1) ? 17'h1FFFF : 17'h0;
         end
         default: begin
            r.temp_centi = TEMP_IN_W'($urandom);
            r.temp_ok    = 1'($urandom);
            r.humid_raw  = HUMID_IN_W'($urandom);
            r.humid_ok   = 1'($urandom);
            r.press_pa   = PRESS_IN_W'($urandom);
         end
      endcase
      r.slope_ack = ($urandom_range(7) == 0);
      return r;
   endfunction

   initial begin : stimulus
      int unsigned    temp_plan[8]  = '{0, 8, 15, 2, 4, 8, 0, 11};
      int unsigned    press_plan[8] = '{8, 0, 3, 15, 4, 0, 8, 1};
      chunk_mode_type mode;
      int             walk;
      int             pick;
      bit             calm;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      walk = 2000;
      mode = MODE_WALK;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_register(CSR_SPARE_LO, 4'hF);
      write_register(CSR_SPARE_HI, 4'h0);
      csr_we <= 1'b0;
      for (int k = 0; k < 20; k++) send_reading(directed_reading(k));
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         write_register(CSR_TEMP_SHIFT, SHIFT_W'(temp_plan[p]));
         write_register(CSR_PRESS_SHIFT, SHIFT_W'(press_plan[p]));
         csr_we <= 1'b0;
         case (p % 4)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct <= 0;
            end
            1: begin
               tx_idle_pct = 47;
               rx_stall_pct <= 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct <= 47;
            end
            default: begin
               tx_idle_pct = 7;
               rx_stall_pct <= 7;
            end
         endcase
         for (int n = 0; n < 225; n++) begin
            if (n % 16 == 0) begin
               pick = $urandom_range(9);
               mode = (pick < 2) ? MODE_EXTREME : (pick == 2) ? MODE_NOISE : MODE_WALK;
               calm = ($urandom_range(3) == 0);
               tx_quiet = calm;
               rx_quiet <= calm;
            end
            if (p == 5 && n == 100) wait_drained();
            send_reading(random_reading(mode, walk));
         end
      end
      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
